[rtl/core/lsd_pkg.sv]
// Shared types, constants and the duty lookup for the LED brightness stepdown unit.
// No dependencies; every other file of the block depends on this package.
package lsd_pkg;

  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  // Highest brightness level; start levels above it saturate.
  localparam level_t LEVEL_MAX = 3'd5;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THRESHOLD    = 3'd0,
    CFG_CRIT_THRESHOLD   = 3'd1,
    CFG_OFF_THRESHOLD    = 3'd2,
    CFG_CRIT_TICKS       = 3'd3,
    CFG_HIGH_TICKS       = 3'd4,
    CFG_TIME_LIMIT_LEVEL = 3'd5,
    CFG_LOW_CAP_LEVEL    = 3'd6,
    CFG_CRIT_FLOOR_LEVEL = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    byte_t  low_threshold;
    byte_t  crit_threshold;
    byte_t  off_threshold;
    byte_t  crit_ticks;
    byte_t  high_ticks;
    level_t time_limit_level;
    level_t low_cap_level;
    level_t crit_floor_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    low_threshold:    8'd132,
    crit_threshold:   8'd128,
    off_threshold:    8'd120,
    crit_ticks:       8'd5,
    high_ticks:       8'd180,
    time_limit_level: 3'd4,
    low_cap_level:    3'd3,
    crit_floor_level: 3'd2
  };

  typedef struct packed {
    level_t level;
    byte_t  high_cnt;
    byte_t  crit_cnt;
    logic   off;
  } state_t;

  typedef struct packed {
    kind_e  kind;
    level_t start_level;
    byte_t  voltage;
  } item_t;

  // PWM compare value per level; levels past the table run at full duty.
  function automatic byte_t duty_of(input level_t lvl);
    byte_t d;
    case (lvl)
      3'd0:    d = 8'd0;
      3'd1:    d = 8'd5;
      3'd2:    d = 8'd13;
      3'd3:    d = 8'd35;
      3'd4:    d = 8'd94;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

endpackage

[rtl/core/lsd_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on lsd_pkg for the field types.
interface lsd_in_if;
  logic             valid;
  logic             ready;
  lsd_pkg::kind_e   kind;
  lsd_pkg::level_t  start_level;
  lsd_pkg::byte_t   voltage;

  modport source (output valid, kind, start_level, voltage, input ready);
  modport sink   (input valid, kind, start_level, voltage, output ready);
endinterface

interface lsd_out_if;
  logic             valid;
  logic             ready;
  lsd_pkg::level_t  level;
  lsd_pkg::byte_t   duty;
  logic             shut_off;

  modport source (output valid, level, duty, shut_off, input ready);
  modport sink   (input valid, level, duty, shut_off, output ready);
endinterface

[rtl/core/led_brightness_stepdown_unit.sv]
// LED brightness stepdown unit: flashlight level limiter on battery voltage.
// Path from input transfer to result valid: input register, then result register.
// Throughput: one item per cycle while the result channel is not stalled; the state
// update between the two registers is combinational. Reset clears both pipeline valids
// and the level/counter/latch state; config registers return to defaults.
module led_brightness_stepdown_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  lsd_pkg::byte_t                cfg_wdata_i,
  lsd_in_if.sink                        in_if,
  lsd_out_if.source                     out_if
);
  import lsd_pkg::*;

  cfg_t   cfg;
  state_t state_q, state_d;
  item_t  item_q, item_d;
  logic   in_vld_q, in_vld_d;
  logic   out_vld_q, out_vld_d;
  level_t out_level_q, out_level_d;
  byte_t  out_duty_q, out_duty_d;
  logic   out_off_q, out_off_d;
  logic   advance;
  logic   in_xfer;

  lsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Item in the input register retires into the result register when that
  // register is empty or its content transfers out this cycle. State is
  // committed at the same edge, so the following item sees it at once.
  assign advance  = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;
  assign in_xfer  = in_if.valid && in_if.ready;

  lsd_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d)
  );

  always_comb begin
    in_vld_d = in_xfer ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    item_d   = item_q;
    if (in_xfer) begin
      item_d.kind        = in_if.kind;
      item_d.start_level = in_if.start_level;
      item_d.voltage     = in_if.voltage;
    end
  end

  always_comb begin
    out_vld_d   = advance ? 1'b1 : ((out_vld_q && out_if.ready) ? 1'b0 : out_vld_q);
    out_level_d = out_level_q;
    out_duty_d  = out_duty_q;
    out_off_d   = out_off_q;
    if (advance) begin
      out_level_d = state_d.level;
      out_duty_d  = state_d.off ? 8'd0 : duty_of(state_d.level);
      out_off_d   = state_d.off;
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    out_level_q <= out_level_d;
    out_duty_q  <= out_duty_d;
    out_off_q   <= out_off_d;
  end

  assign out_if.valid    = out_vld_q;
  assign out_if.level    = out_level_q;
  assign out_if.duty     = out_duty_q;
  assign out_if.shut_off = out_off_q;

endmodule

[rtl/core/lsd_cfg_regs.sv]
// Configuration register file: eight write-only limit and threshold registers.
// Depends on lsd_pkg.
module lsd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  lsd_pkg::byte_t                cfg_wdata_i,
  output lsd_pkg::cfg_t                 cfg_o
);
  import lsd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_THRESHOLD:    cfg_d.low_threshold    = cfg_wdata_i;
        CFG_CRIT_THRESHOLD:   cfg_d.crit_threshold   = cfg_wdata_i;
        CFG_OFF_THRESHOLD:    cfg_d.off_threshold    = cfg_wdata_i;
        CFG_CRIT_TICKS:       cfg_d.crit_ticks       = cfg_wdata_i;
        CFG_HIGH_TICKS:       cfg_d.high_ticks       = cfg_wdata_i;
        CFG_TIME_LIMIT_LEVEL: cfg_d.time_limit_level = cfg_wdata_i[LEVEL_W-1:0];
        CFG_LOW_CAP_LEVEL:    cfg_d.low_cap_level    = cfg_wdata_i[LEVEL_W-1:0];
        CFG_CRIT_FLOOR_LEVEL: cfg_d.crit_floor_level = cfg_wdata_i[LEVEL_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/lsd_step.sv]
// Next-state logic for one item: start load, time limit, low-voltage cap,
// critical-voltage step down and shut-off latch. Depends on lsd_pkg.
module lsd_step (
  input  lsd_pkg::cfg_t   cfg_i,
  input  lsd_pkg::state_t state_i,
  input  lsd_pkg::item_t  item_i,
  output lsd_pkg::state_t state_o
);
  import lsd_pkg::*;

  byte_t  hc_inc, cc_inc;
  level_t lvl_time, lvl_cap;
  logic   hc_hit, cc_hit;

  always_comb begin
    // time limit
    hc_inc   = (state_i.level > cfg_i.time_limit_level) ? state_i.high_cnt + 8'd1 : 8'd0;
    hc_hit   = (hc_inc >= cfg_i.high_ticks);
    lvl_time = state_i.level;
    if (hc_hit && state_i.level != '0) begin
      lvl_time = state_i.level - 3'd1;
    end

    // low voltage cap
    lvl_cap = lvl_time;
    if (item_i.voltage < cfg_i.low_threshold && lvl_time > cfg_i.low_cap_level) begin
      lvl_cap = cfg_i.low_cap_level;
    end

    // critical voltage
    cc_inc = (item_i.voltage < cfg_i.crit_threshold) ? state_i.crit_cnt + 8'd1 : 8'd0;
    cc_hit = (cc_inc >= cfg_i.crit_ticks);

    state_o = state_i;
    if (item_i.kind == KIND_START) begin
      state_o.level    = (item_i.start_level > LEVEL_MAX) ? LEVEL_MAX : item_i.start_level;
      state_o.high_cnt = '0;
      state_o.crit_cnt = '0;
      state_o.off      = 1'b0;
    end else if (!state_i.off) begin
      state_o.high_cnt = hc_hit ? 8'd0 : hc_inc;
      state_o.crit_cnt = cc_hit ? 8'd0 : cc_inc;
      state_o.level    = lvl_cap;
      if (cc_hit) begin
        if (lvl_cap > cfg_i.crit_floor_level) begin
          state_o.level = lvl_cap - 3'd1;
        end else if (item_i.voltage < cfg_i.off_threshold) begin
          state_o.off = 1'b1;
        end
      end
    end
  end

endmodule
